### rtl/jse_pkg.sv
// Package for the JSON string escaper with UTF-8 check.
// Holds the channel payload types, the job type passed front to back and the
// job queue sizing. No dependencies.
package jse_pkg;

  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = $clog2(JQ_DEPTH);
  localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);

  localparam int ACC_W    = 21;
  localparam int LIT_N    = 6;

  localparam logic [7:0] REP_B0 = 8'hEF;
  localparam logic [7:0] REP_B1 = 8'hBF;
  localparam logic [7:0] REP_B2 = 8'hBD;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       output_done;
  } out_t;

  // One item's output: rep replacement characters, then lcnt literal bytes.
  typedef struct packed {
    logic [2:0]             rep;
    logic [2:0]             lcnt;
    logic [LIT_N-1:0][7:0]  lit;
    logic                   last;
  } job_t;

endpackage

### rtl/jse_front.sv
// Front end: classifies each input byte, tracks the pending UTF-8 sequence
// and builds at most one job per transfer. Depends on jse_pkg.
module jse_front import jse_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic acc_in,
  input  in_t  in_data,
  output logic job_valid,
  output job_t job
);

  logic [1:0]       hc_r, hc_nxt;
  logic [2:0]       len_r, len_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [7:0]       hb_r [3];

  logic             hb_we;
  logic [1:0]       hb_idx;
  logic [7:0]       c;
  logic             last;
  logic             cont;
  logic             start;
  logic [2:0]       pre_rep;
  logic [2:0]       lead_len;
  logic [ACC_W-1:0] lead_bits;
  logic [ACC_W-1:0] acc_c;
  logic             ok;
  logic [7:0]       short_ch;

  function automatic logic [7:0] hex_ch(input logic [3:0] v);
    hex_ch = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
  endfunction

  assign c    = in_data.in_byte;
  assign last = in_data.string_end;
  assign cont = (c[7:6] == 2'b10);

  always_comb begin
    lead_len  = 3'd0;
    lead_bits = '0;
    if (c[7:5] == 3'b110) begin
      lead_len  = 3'd2;
      lead_bits = {16'h0, c[4:0]};
    end else if (c[7:4] == 4'b1110) begin
      lead_len  = 3'd3;
      lead_bits = {17'h0, c[3:0]};
    end else if (c[7:3] == 5'b11110) begin
      lead_len  = 3'd4;
      lead_bits = {18'h0, c[2:0]};
    end
  end

  always_comb begin
    unique case (c)
      8'h22:   short_ch = 8'h22;
      8'h5C:   short_ch = 8'h5C;
      8'h08:   short_ch = 8'h62;
      8'h0C:   short_ch = 8'h66;
      8'h0A:   short_ch = 8'h6E;
      8'h0D:   short_ch = 8'h72;
      8'h09:   short_ch = 8'h74;
      default: short_ch = 8'h00;
    endcase
  end

  assign acc_c = {acc_r[ACC_W-7:0], c[5:0]};

  always_comb begin
    ok = 1'b1;
    if ((len_r == 3'd2 && acc_c < 21'h80) ||
        (len_r == 3'd3 && acc_c < 21'h800) ||
        (len_r == 3'd4 && acc_c < 21'h10000))
      ok = 1'b0;
    if (acc_c > 21'h10FFFF || (acc_c >= 21'hD800 && acc_c <= 21'hDFFF))
      ok = 1'b0;
  end

  always_comb begin
    job      = '0;
    job.last = last;
    hc_nxt   = hc_r;
    len_nxt  = len_r;
    acc_nxt  = acc_r;
    hb_we    = 1'b0;
    hb_idx   = 2'd0;
    start    = 1'b0;
    pre_rep  = 3'd0;

    if (hc_r == 2'd0) begin
      start = 1'b1;
    end else if (!cont) begin
      pre_rep = {1'b0, hc_r};
      start   = 1'b1;
      hc_nxt  = 2'd0;
    end else begin
      acc_nxt = acc_c;
      if (({1'b0, hc_r} + 3'd1) >= len_r) begin
        if (ok) begin
          for (int i = 0; i < 3; i++) begin
            if (i < int'(hc_r)) job.lit[i] = hb_r[i];
          end
          job.lit[{1'b0, hc_r}] = c;
          job.lcnt = {1'b0, hc_r} + 3'd1;
        end else begin
          job.rep = {1'b0, hc_r} + 3'd1;
        end
        hc_nxt  = 2'd0;
        acc_nxt = '0;
      end else begin
        hb_we  = 1'b1;
        hb_idx = hc_r;
        hc_nxt = hc_r + 2'd1;
        if (last) job.rep = {1'b0, hc_r} + 3'd1;
      end
    end

    if (start) begin
      job.rep = pre_rep;
      if (!c[7]) begin
        if (short_ch != 8'h00) begin
          job.lit[0] = 8'h5C;
          job.lit[1] = short_ch;
          job.lcnt   = 3'd2;
        end else if (c < 8'h20) begin
          job.lit[0] = 8'h5C;
          job.lit[1] = 8'h75;
          job.lit[2] = 8'h30;
          job.lit[3] = 8'h30;
          job.lit[4] = hex_ch(c[7:4]);
          job.lit[5] = hex_ch(c[3:0]);
          job.lcnt   = 3'd6;
        end else begin
          job.lit[0] = c;
          job.lcnt   = 3'd1;
        end
      end else if (lead_len == 3'd0 || last) begin
        job.rep = pre_rep + 3'd1;
      end else begin
        hb_we   = 1'b1;
        hb_idx  = 2'd0;
        hc_nxt  = 2'd1;
        len_nxt = lead_len;
        acc_nxt = lead_bits;
      end
    end

    if (last) begin
      hc_nxt  = 2'd0;
      len_nxt = 3'd0;
      acc_nxt = '0;
    end

    job_valid = acc_in && (job.rep != 3'd0 || job.lcnt != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r  <= 2'd0;
      len_r <= 3'd0;
      acc_r <= '0;
    end else if (acc_in) begin
      hc_r  <= hc_nxt;
      len_r <= len_nxt;
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in && hb_we) hb_r[hb_idx] <= c;
  end

  a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (hc_r != 2'd0) |-> (len_r >= 3'd2 && len_r <= 3'd4))
    else $error("pending sequence without valid length");

  a_hc_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (hc_r != 2'd0) |-> ({1'b0, hc_r} < len_r))
    else $error("held count reached sequence length");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && last) |=> (hc_r == 2'd0))
    else $error("state not cleared after string end");

endmodule

### rtl/jse_jobq.sv
// Short job queue between front and back ends, JQ_DEPTH entries.
// Depends on jse_pkg.
module jse_jobq import jse_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head
);

  job_t             mem_r [JQ_DEPTH];
  logic [JQ_AW-1:0] wp_r, rp_r;
  logic [JQ_CW-1:0] cnt_r;

  assign full  = (cnt_r == JQ_CW'(JQ_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + JQ_AW'(1);
      if (pop)  rp_r <= rp_r + JQ_AW'(1);
      if (push && !pop)      cnt_r <= cnt_r + JQ_CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - JQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= JQ_CW'(JQ_DEPTH))
    else $error("job queue count overflow");

endmodule

### rtl/jse_back.sv
// Back end: expands the job at the queue head into output bytes, one per
// cycle while the output register is empty or popped, into the output register. Depends on jse_pkg.
module jse_back import jse_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  job_t head,
  output logic q_pop,
  output logic out_empty,
  input  logic out_pop,
  output out_t out_data
);

  logic [2:0] rep_done_r;
  logic [1:0] phase_r;
  logic [2:0] lidx_r;
  logic       ov_r;
  out_t       od_r;

  logic       in_rep;
  logic       job_end;
  logic       step;
  logic [7:0] cur_byte;

  assign in_rep = (rep_done_r < head.rep);

  always_comb begin
    if (in_rep) begin
      unique case (phase_r)
        2'd0:    cur_byte = REP_B0;
        2'd1:    cur_byte = REP_B1;
        default: cur_byte = REP_B2;
      endcase
      job_end = (phase_r == 2'd2) && ((rep_done_r + 3'd1) == head.rep) &&
                (head.lcnt == 3'd0);
    end else begin
      cur_byte = head.lit[lidx_r];
      job_end  = ((lidx_r + 3'd1) == head.lcnt);
    end
  end

  assign step      = q_valid && (!ov_r || out_pop);
  assign q_pop     = step && job_end;
  assign out_empty = !ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_done_r <= 3'd0;
      phase_r    <= 2'd0;
      lidx_r     <= 3'd0;
      ov_r       <= 1'b0;
    end else begin
      if (step) begin
        ov_r <= 1'b1;
        if (job_end) begin
          rep_done_r <= 3'd0;
          phase_r    <= 2'd0;
          lidx_r     <= 3'd0;
        end else if (in_rep) begin
          if (phase_r == 2'd2) begin
            phase_r    <= 2'd0;
            rep_done_r <= rep_done_r + 3'd1;
          end else begin
            phase_r <= phase_r + 2'd1;
          end
        end else begin
          lidx_r <= lidx_r + 3'd1;
        end
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      od_r.out_byte    <= cur_byte;
      od_r.run_end     <= job_end;
      od_r.output_done <= job_end && head.last;
    end
  end

  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (head.rep != 3'd0 || head.lcnt != 3'd0))
    else $error("empty job in queue");

  a_done_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && od_r.output_done) |-> od_r.run_end)
    else $error("string end flagged off a run end");

endmodule

### rtl/json_string_escaper_utf8_check.sv
// Top level of the JSON string escaper with UTF-8 check.
// Instantiates jse_front, jse_jobq and jse_back; depends on jse_pkg.
//
// Input channel: in_push / in_full carry one string byte and its end flag per
// transfer. Output channel: out_empty / out_pop carry one escaped byte per
// transfer, with run_end on the last byte caused by an input byte and
// output_done on the last byte of the whole string.
// With an empty queue, the job of an input byte enters the queue at its
// transfer edge and the output register then loads the first output byte
// from the queue head.
// The back end emits one byte per cycle while the receiver takes them; an
// input byte that maps to one output byte then sustains one transfer per cycle.
// Escapes give 2 or 6 bytes, replacements 3 each, up to 15 bytes per input.
// Bytes of a pending UTF-8 sequence produce nothing until it ends or breaks.
// The 4-entry job queue absorbs expansion; in_full rises when it fills.
// When the receiver stalls, the output register holds and the queue fills.
// Reset clears the pending sequence, the queue and the output valid flag.
module json_string_escaper_utf8_check import jse_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  in_t  in_data,
  output logic out_empty,
  input  logic out_pop,
  output out_t out_data
);

  logic acc_in;
  logic job_valid;
  job_t job;
  logic q_valid;
  logic q_pop;
  job_t head;

  assign acc_in = in_push && !in_full;

  jse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_in    (acc_in),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job       (job)
  );

  jse_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid),
    .push_job (job),
    .full     (in_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head)
  );

  jse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

### tb/sv/tb_json_string_escaper_utf8_check.sv
`timescale 1ns / 100ps
// Testbench for json_string_escaper_utf8_check: streams directed and random strings,
// predicts the escaped byte stream and checks each output transfer field by field.
// Depends on jse_pkg and the escaper RTL.
module tb_json_string_escaper_utf8_check;
  import jse_pkg::*;

  localparam logic [7:0] ASC_QUOTE = 8'h22;
  localparam logic [7:0] ASC_BSL   = 8'h5C;
  localparam logic [7:0] ASC_B     = 8'h62;
  localparam logic [7:0] ASC_F     = 8'h66;
  localparam logic [7:0] ASC_N     = 8'h6E;
  localparam logic [7:0] ASC_R     = 8'h72;
  localparam logic [7:0] ASC_T     = 8'h74;
  localparam logic [7:0] ASC_U     = 8'h75;
  localparam logic [7:0] ASC_0     = 8'h30;
  localparam logic [7:0] ASC_LC_A  = 8'h61;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_TAB   = 8'h09;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_FF    = 8'h0C;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [20:0] CP_2MIN  = 21'h80;
  localparam logic [20:0] CP_3MIN  = 21'h800;
  localparam logic [20:0] CP_4MIN  = 21'h10000;
  localparam logic [20:0] CP_MAX   = 21'h10FFFF;
  localparam logic [20:0] SURR_LO  = 21'hD800;
  localparam logic [20:0] SURR_HI  = 21'hDFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_t  in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_t out_data;

  in_t        raw_q[$];
  in_t        text_q[$];
  out_t       escaped_q[$];
  logic [7:0] esc_bytes[$];

  logic [1:0]  hold_n = '0;
  logic [2:0]  seq_len = '0;
  logic [7:0]  hold_b[3];
  logic [20:0] cp_acc = '0;

  int   err_cnt = 0;
  int   cyc = 0;
  int   in_gap = 0;
  int   out_gap = 0;
  out_t want;

  json_string_escaper_utf8_check uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function void drop_seq();
    hold_n  = '0;
    seq_len = '0;
    cp_acc  = '0;
  endfunction

  function void add_byte(logic [7:0] b);
    esc_bytes.insert(esc_bytes.size(), b);
  endfunction

  function void put_rep(int cnt);
    for (int i = 0; i < cnt; i++) begin
      add_byte(REP_B0);
      add_byte(REP_B1);
      add_byte(REP_B2);
    end
  endfunction

  // Byte arriving with no sequence pending.
  function void lead_byte(logic [7:0] c, logic last);
    logic [7:0]  sc;
    logic [2:0]  len;
    logic [20:0] lb;
    sc  = '0;
    len = '0;
    lb  = '0;
    if (c < 8'h80) begin
      case (c)
        ASC_QUOTE: sc = ASC_QUOTE;
        ASC_BSL:   sc = ASC_BSL;
        CTL_BS:    sc = ASC_B;
        CTL_FF:    sc = ASC_F;
        CTL_LF:    sc = ASC_N;
        CTL_CR:    sc = ASC_R;
        CTL_TAB:   sc = ASC_T;
        default:   sc = '0;
      endcase
      if (sc != 8'h00) begin
        add_byte(ASC_BSL);
        add_byte(sc);
      end else if (c < 8'h20) begin
        add_byte(ASC_BSL);
        add_byte(ASC_U);
        add_byte(ASC_0);
        add_byte(ASC_0);
        add_byte(8'(ASC_0 + c[7:4]));
        add_byte((c[3:0] < 4'd10) ? 8'(ASC_0 + c[3:0]) :
                 8'(ASC_LC_A + c[3:0] - 8'd10));
      end else begin
        add_byte(c);
      end
    end else begin
      if (c[7:5] == 3'b110) begin
        len = 3'd2;
        lb  = 21'(c[4:0]);
      end else if (c[7:4] == 4'b1110) begin
        len = 3'd3;
        lb  = 21'(c[3:0]);
      end else if (c[7:3] == 5'b11110) begin
        len = 3'd4;
        lb  = 21'(c[2:0]);
      end
      if (len == 3'd0 || last) begin
        put_rep(1);
      end else begin
        hold_b[0] = c;
        hold_n    = 2'd1;
        seq_len   = len;
        cp_acc    = lb;
      end
    end
  endfunction

  // Predicts the escaped bytes caused by one accepted input transfer.
  function void escape_byte(in_t it);
    logic [7:0] c;
    logic       last;
    logic       ok;
    int         n;
    out_t       r;
    c    = it.in_byte;
    last = it.string_end;
    esc_bytes.delete();
    if (hold_n == 2'd0) begin
      lead_byte(c, last);
    end else if (c[7:6] != 2'b10) begin
      put_rep(int'(hold_n));
      drop_seq();
      lead_byte(c, last);
    end else begin
      cp_acc = {cp_acc[14:0], c[5:0]};
      if (int'(hold_n) + 1 >= int'(seq_len)) begin
        ok = 1'b1;
        if ((seq_len == 3'd2 && cp_acc < CP_2MIN) || (seq_len == 3'd3 && cp_acc < CP_3MIN) ||
            (seq_len == 3'd4 && cp_acc < CP_4MIN))
          ok = 1'b0;
        if (cp_acc > CP_MAX || (cp_acc >= SURR_LO && cp_acc <= SURR_HI))
          ok = 1'b0;
        if (ok) begin
          for (int i = 0; i < int'(hold_n); i++)
            add_byte(hold_b[i]);
          add_byte(c);
        end else begin
          put_rep(int'(hold_n) + 1);
        end
        drop_seq();
      end else begin
        hold_b[hold_n] = c;
        hold_n = hold_n + 2'd1;
        if (last) begin
          put_rep(int'(hold_n));
          drop_seq();
        end
      end
    end
    n = esc_bytes.size();
    for (int i = 0; i < n; i++) begin
      r.out_byte    = esc_bytes[i];
      r.run_end     = (i == n - 1);
      r.output_done = (i == n - 1) && last;
      escaped_q.insert(escaped_q.size(), r);
    end
    if (last)
      drop_seq();
  endfunction

  // Mostly short gaps, a few long ones, and periodic stretches with none.
  function int pick_gap();
    int r;
    if ((cyc % 500) < 80)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 70)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function void put_raw(logic [7:0] b);
    in_t it;
    it.in_byte    = b;
    it.string_end = 1'b0;
    text_q.insert(text_q.size(), it);
  endfunction

  function void close_string();
    text_q[text_q.size() - 1].string_end = 1'b1;
    foreach (text_q[i])
      raw_q.insert(raw_q.size(), text_q[i]);
    text_q.delete();
  endfunction

  // Driver: holds an item until its transfer, then optionally idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        escape_byte(in_data);
        void'(raw_q.pop_front());
        in_gap = pick_gap();
      end
      if (!(in_push && in_full)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_push <= 1'b0;
        end else if (raw_q.size() > 0) begin
          in_push <= 1'b1;
          in_data <= raw_q[0];
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output transfer against the oldest prediction.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (escaped_q.size() == 0) begin
          err_cnt++;
          $error("unexpected output transfer: out_byte %h", out_data.out_byte);
        end else begin
          want = escaped_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            err_cnt++;
            $error("out_byte mismatch: expected %h, got %h", want.out_byte, out_data.out_byte);
          end
          if (out_data.run_end !== want.run_end) begin
            err_cnt++;
            $error("run_end mismatch: expected %b, got %b", want.run_end, out_data.run_end);
          end
          if (out_data.output_done !== want.output_done) begin
            err_cnt++;
            $error("output_done mismatch: expected %b, got %b",
                   want.output_done, out_data.output_done);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  initial begin
    int          n_rand;
    int          elems;
    int          kind;
    int          pick;
    int          len;
    int          nb;
    logic [7:0]  pfx;
    logic [20:0] lo;
    logic [20:0] hi;
    logic [20:0] cp;

    // Escapes, control codes and pass-through edges.
    put_raw(ASC_QUOTE); put_raw(ASC_BSL); put_raw(CTL_BS); put_raw(CTL_FF); put_raw(CTL_LF);
    put_raw(CTL_CR); put_raw(CTL_TAB); put_raw(8'h00); put_raw(8'h1F); put_raw(8'h7F);
    close_string();
    // Bad leads, then valid 2- and 3-byte sequences.
    put_raw(8'h80); put_raw(8'hFF); put_raw(8'hC3); put_raw(8'hA9);
    put_raw(8'hE2); put_raw(8'h82); put_raw(8'hAC);
    close_string();
    // Valid 4-byte sequence, then an overlong C0 form.
    put_raw(8'hF0); put_raw(8'h9F); put_raw(8'h98); put_raw(8'h80);
    put_raw(8'hC0); put_raw(8'h80);
    close_string();
    // Sequence broken by ASCII, then one cut off by string end.
    put_raw(8'hC3); put_raw(8'h41); put_raw(8'hE2); put_raw(8'h82);
    close_string();
    // Lead byte as the last byte.
    put_raw(8'hC3);
    close_string();

    n_rand = 0;
    while (n_rand < 200) begin
      elems = $urandom_range(1, 8);
      repeat (elems) begin
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
          pick = $urandom_range(0, 9);
          if (pick < 3)
            put_raw(8'($urandom_range(0, 31)));
          else if (pick == 3)
            put_raw(ASC_QUOTE);
          else if (pick == 4)
            put_raw(ASC_BSL);
          else
            put_raw(8'($urandom_range(0, 127)));
        end else if (kind < 90) begin
          len = $urandom_range(2, 4);
          case (len)
            2: begin
              pfx = 8'hC0;
              lo  = CP_2MIN;
              hi  = 21'h7FF;
            end
            3: begin
              pfx = 8'hE0;
              lo  = CP_3MIN;
              hi  = 21'hFFFF;
            end
            default: begin
              pfx = 8'hF0;
              lo  = CP_4MIN;
              hi  = CP_MAX;
            end
          endcase
          pick = $urandom_range(0, 9);
          if (pick < 5)
            cp = 21'($urandom_range(lo, hi));
          else if (pick < 7 && len == 3)
            cp = 21'($urandom_range(SURR_LO, SURR_HI));
          else if (pick < 7 && len == 4)
            cp = 21'($urandom_range(CP_MAX + 21'd1, 21'h1FFFFF));
          else
            cp = 21'($urandom_range(0, (len == 4) ? 21'h1FFFFF : hi));
          // Upper part of this range makes sequences that stop short.
          nb = (kind < 75) ? len : $urandom_range(1, len - 1);
          put_raw(8'(pfx | (cp >> (6 * (len - 1)))));
          for (int k = len - 2; k >= len - nb; k--)
            put_raw(8'(8'h80 | ((cp >> (6 * k)) & 21'h3F)));
        end else begin
          put_raw(8'($urandom_range(0, 255)));
        end
      end
      n_rand += text_q.size();
      close_string();
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (raw_q.size() != 0 || escaped_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
